// ----- rtl/core/spq_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and codes of the sorted priority queue.
package spq_pkg;

   localparam int Capacity     = 16;
   localparam int PayloadBits  = 32;
   localparam int PriorityBits = 16;
   localparam int CountBits    = $clog2(Capacity + 1);

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_LIST   = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_INSERT,
      CMD_DELETE,
      CMD_ROTATE
   } cmd_op_type;

   typedef enum logic {
      ST_IDLE,
      ST_LIST
   } state_type;

   typedef struct packed {
      logic [1:0]              opcode;
      logic [PayloadBits-1:0]  item_payload;
      logic [PriorityBits-1:0] item_priority;
   } req_word_type;

   typedef struct packed {
      logic [PayloadBits-1:0]  out_payload;
      logic [PriorityBits-1:0] out_priority;
      status_type              status;
      logic                    last_of_run;
   } rsp_word_type;

   typedef struct packed {
      logic                    valid;
      logic [PayloadBits-1:0]  payload;
      logic [PriorityBits-1:0] priority_val;
   } entry_type;

   typedef struct packed {
      cmd_op_type              op;
      logic [PayloadBits-1:0]  payload;
      logic [PriorityBits-1:0] priority_val;
   } cmd_type;

   typedef struct packed {
      entry_type head;
      logic      empty;
      logic      full;
   } chain_status_type;

endpackage

// ----- rtl/core/spq_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channels for request and response words.
interface spq_req_if;
   import spq_pkg::*;

   logic         valid;
   logic         ready;
   req_word_type word;

   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

interface spq_rsp_if;
   import spq_pkg::*;

   logic         valid;
   logic         ready;
   rsp_word_type word;

   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

// ----- rtl/core/sorted_priority_queue_unit.sv -----
`timescale 1ns / 1ps
// Sorted priority queue: a chain of cells kept in ascending priority order.
//
// Request channel req_ch carries opcode, item_payload and item_priority.
// Insert places the entry behind all entries of lower or equal priority,
// delete returns the head entry, list streams every entry head to tail.
// Response channel rsp_ch carries out_payload, out_priority, status and
// last_of_run; every request but the unused opcode gives at least one word.
// The response word is registered and appears in the cycle after the
// request is accepted.
// Insert and delete go back to back while the receiver keeps up. A list
// of n entries gives n words, one per cycle while the receiver keeps up,
// as the cell row rotates once; no request is taken meanwhile.
// An insert into a full queue is dropped with status full; a delete or a
// list of an empty queue gives one word with status empty.
// Reset (synchronous) empties the queue and drops any pending response.
// When rsp_ch stalls, the response word holds and req_ch.ready goes low
// until the word is taken; the cell row does not move.
module sorted_priority_queue_unit (
   input  logic      clock,
   input  logic      reset,
   spq_req_if.sink   req_ch,
   spq_rsp_if.source rsp_ch
);
   import spq_pkg::*;

   state_type              state_ff, state_in;
   logic [CountBits-1:0]   count_ff, count_in;
   logic [CountBits-1:0]   left_ff, left_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_word_type           rsp_word_ff, rsp_word_in;
   cmd_type                cmd;
   chain_status_type       chain_st;
   logic                   out_free;
   logic                   req_fire;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire = req_ch.valid && req_ch.ready;

   spq_chain u_chain (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .status (chain_st)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      left_in      = left_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_word_in  = rsp_word_ff;
      req_ch.ready = 1'b0;
      cmd          = '{op: CMD_HOLD,
                       payload: req_ch.word.item_payload,
                       priority_val: req_ch.word.item_priority};
      unique case (state_ff)
         ST_IDLE: begin
            req_ch.ready = out_free;
            if (req_ch.valid && out_free) begin
               rsp_word_in = '{out_payload: '0, out_priority: '0,
                               status: STATUS_OK, last_of_run: 1'b1};
               rsp_valid_in = 1'b1;
               case (opcode_type'(req_ch.word.opcode))
                  OP_INSERT: begin
                     if (chain_st.full) begin
                        rsp_word_in.status = STATUS_FULL;
                     end else begin
                        cmd.op   = CMD_INSERT;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_DELETE: begin
                     if (chain_st.empty) begin
                        rsp_word_in.status = STATUS_EMPTY;
                     end else begin
                        rsp_word_in.out_payload  = chain_st.head.payload;
                        rsp_word_in.out_priority = chain_st.head.priority_val;
                        cmd.op   = CMD_DELETE;
                        count_in = count_ff - 1'b1;
                     end
                  end
                  OP_LIST: begin
                     if (chain_st.empty) begin
                        rsp_word_in.status = STATUS_EMPTY;
                     end else begin
                        rsp_word_in.out_payload  = chain_st.head.payload;
                        rsp_word_in.out_priority = chain_st.head.priority_val;
                        rsp_word_in.last_of_run  = (count_ff == CountBits'(1));
                        cmd.op  = CMD_ROTATE;
                        left_in = count_ff - 1'b1;
                        if (count_ff != CountBits'(1)) begin
                           state_in = ST_LIST;
                        end
                     end
                  end
                  default: begin
                     // unused opcode: drop without a response
                     rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
                     rsp_word_in  = rsp_word_ff;
                  end
               endcase
            end
         end
         ST_LIST: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = '{out_payload: chain_st.head.payload,
                                out_priority: chain_st.head.priority_val,
                                status: STATUS_OK,
                                last_of_run: (left_ff == CountBits'(1))};
               cmd.op  = CMD_ROTATE;
               left_in = left_ff - 1'b1;
               if (left_ff == CountBits'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.word  = rsp_word_ff;

`ifndef ASSERT_OFF
   a_count_tracks_head : assert property (@(posedge clock) disable iff (reset)
      chain_st.empty == (count_ff == '0))
      else $error("entry count disagrees with head cell valid");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountBits'(Capacity))
      else $error("entry count beyond capacity");

   a_full_insert_drop : assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_ch.word.opcode == OP_INSERT) && chain_st.full
      |=> $stable(count_ff) && rsp_ch.valid && (rsp_ch.word.status == STATUS_FULL))
      else $error("insert into full queue not dropped");

   a_list_blocks_req : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LIST) |-> !req_ch.ready)
      else $error("request taken while listing");
`endif

endmodule

// ----- rtl/core/spq_cell.sv -----
`timescale 1ns / 1ps
// One queue slot: holds an entry and trades it with its neighbors.
module spq_cell (
   input  logic              clock,
   input  logic              reset,
   input  spq_pkg::cmd_type   cmd,
   input  spq_pkg::entry_type head,
   input  spq_pkg::entry_type left_entry,
   input  logic              left_keep,
   input  spq_pkg::entry_type right_entry,
   output spq_pkg::entry_type entry,
   output logic              keep
);
   import spq_pkg::*;

   logic                    valid_ff, valid_in;
   logic [PayloadBits-1:0]  payload_ff, payload_in;
   logic [PriorityBits-1:0] priority_ff, priority_in;

   // entries at or ahead of an equal priority stay put on insert
   assign keep  = valid_ff && (priority_ff <= cmd.priority_val);
   assign entry = '{valid: valid_ff, payload: payload_ff, priority_val: priority_ff};

   always_comb begin
      valid_in    = valid_ff;
      payload_in  = payload_ff;
      priority_in = priority_ff;
      case (cmd.op)
         CMD_INSERT: begin
            if (!keep) begin
               if (left_keep) begin
                  valid_in    = 1'b1;
                  payload_in  = cmd.payload;
                  priority_in = cmd.priority_val;
               end else begin
                  valid_in    = left_entry.valid;
                  payload_in  = left_entry.payload;
                  priority_in = left_entry.priority_val;
               end
            end
         end
         CMD_DELETE: begin
            valid_in    = right_entry.valid;
            payload_in  = right_entry.payload;
            priority_in = right_entry.priority_val;
         end
         CMD_ROTATE: begin
            // advance toward the head; the tail slot takes the old head
            if (right_entry.valid) begin
               payload_in  = right_entry.payload;
               priority_in = right_entry.priority_val;
            end else if (valid_ff) begin
               payload_in  = head.payload;
               priority_in = head.priority_val;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      payload_ff  <= payload_in;
      priority_ff <= priority_in;
   end

endmodule

// ----- rtl/core/spq_chain.sv -----
`timescale 1ns / 1ps
// Row of queue cells, head at cell zero.
module spq_chain (
   input  logic                     clock,
   input  logic                     reset,
   input  spq_pkg::cmd_type          cmd,
   output spq_pkg::chain_status_type status
);
   import spq_pkg::*;

   entry_type entries [Capacity];
   logic      keeps   [Capacity];

   for (genvar i = 0; i < Capacity; i++) begin : g_cell
      entry_type left_entry, right_entry;
      logic      left_keep;

      if (i == 0) begin : g_first
         assign left_entry = '0;
         assign left_keep  = 1'b1;
      end else begin : g_mid
         assign left_entry = entries[i-1];
         assign left_keep  = keeps[i-1];
      end

      if (i == Capacity - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_inner
         assign right_entry = entries[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .head        (entries[0]),
         .left_entry  (left_entry),
         .left_keep   (left_keep),
         .right_entry (right_entry),
         .entry       (entries[i]),
         .keep        (keeps[i])
      );
   end

   assign status.head  = entries[0];
   assign status.empty = !entries[0].valid;
   assign status.full  = entries[Capacity-1].valid;

endmodule
